// ----- rtl/fm_register_write_monitor_core_assert.svh -----
// assertion macros for the fm register write monitor
`ifndef FM_REGISTER_WRITE_MONITOR_CORE_ASSERT_SVH
`define FM_REGISTER_WRITE_MONITOR_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define FMWM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FMWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/fmwm_pkg.sv -----
// shared types, codes and tables of the fm register write monitor
package fmwm_pkg;

  // input commands
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam int NUM_CHANNELS = 8;
  localparam int CH_BITS      = 3;

  // register map landmarks
  localparam logic [7:0] ADDR_KEY      = 8'h08;
  localparam logic [7:0] ADDR_CHAN_LO  = 8'h20;
  localparam logic [7:0] ADDR_ALG_HI   = 8'h27;
  localparam logic [7:0] ADDR_KC_LO    = 8'h28;
  localparam logic [7:0] ADDR_KC_HI    = 8'h37;
  localparam logic [7:0] ADDR_TL_LO    = 8'h60;
  localparam logic [7:0] ADDR_TL_HI    = 8'h7F;

  localparam logic [7:0] HOLD_RESET = 8'd60;
  localparam logic [6:0] NOTE_MAX   = 7'd127;

  // reciprocal of three for sums below 512
  localparam logic [8:0] RECIP3     = 9'd171;

  // what the current item needs from the shadow memory
  typedef enum logic [2:0] {
    K_PLAIN = 3'd0,
    K_NOTE  = 3'd1,
    K_VEL   = 3'd2,
    K_READ  = 3'd3,
    K_TICK  = 3'd4
  } kind_t;

  // semitone within octave for the low key code nibble
  function automatic logic [3:0] kc_note(input logic [3:0] kc);
    logic [3:0] r;
    case (kc)
      4'd0:  r = 4'd1;
      4'd1:  r = 4'd2;
      4'd2:  r = 4'd3;
      4'd3:  r = 4'd4;
      4'd4:  r = 4'd4;
      4'd5:  r = 4'd5;
      4'd6:  r = 4'd6;
      4'd7:  r = 4'd7;
      4'd8:  r = 4'd7;
      4'd9:  r = 4'd8;
      4'd10: r = 4'd9;
      4'd11: r = 4'd10;
      4'd12: r = 4'd10;
      4'd13: r = 4'd11;
      4'd14: r = 4'd12;
      default: r = 4'd12;
    endcase
    return r;
  endfunction

  // carrier operators of each algorithm, bit i is operator i
  function automatic logic [3:0] carrier_bits(input logic [2:0] alg);
    logic [3:0] r;
    case (alg)
      3'd0, 3'd1, 3'd2: r = 4'h8;
      3'd3, 3'd4:       r = 4'hA;
      3'd5, 3'd6:       r = 4'hE;
      default:          r = 4'hF;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/fm_register_write_monitor_core.sv -----
// fm register write monitor: shadow memory, per-channel state and reporting
//
//  port group   dir  tdata / tuser contents (low bit first)
//  in_*         in   tuser: command[1:0]; tdata: reg_addr[7:0], reg_data[15:8]
//  out_*        out  tdata: channel, note, velocity, key_on, slot_mask,
//                    key_edge, write_count, write_peak, reg_value; tlast: last
//  cfg_*        in   cfg_wdata: hold_ticks, written when cfg_we is high
//
// after reset a clearing pass zeroes the 256-entry shadow while in_tready is low.
// reads: none for a plain write, one for a key code write, a read or a frame tick,
// five for an algorithm/total level write (one read port); ticks emit 8 results.
// the result register lets the next item enter while the last result waits;
// a stalled out_tready stops the sequencer only when it has a result to hand over.
module fm_register_write_monitor_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // reg_addr[7:0], reg_data[15:8]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // channel[2:0], note[9:3], velocity[16:10],
                                  // key_on[17], slot_mask[21:18],
                                  // key_edge[23:22], write_count[39:24],
                                  // write_peak[55:40], reg_value[63:56]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import fmwm_pkg::*;

  typedef enum logic [6:0] {
    ST_CLR   = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_RD    = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_CALC  = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_TICK  = 7'b1000000
  } state_t;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  state_t state_r, state_nxt;

  // configuration
  logic [7:0] hold_cfg_r;

  // item context
  kind_t               kind_r;
  logic [7:0]          addr_r;
  logic [CH_BITS-1:0]  ch_r;
  logic [1:0]          edge_r;
  logic [7:0]          reg_val_r;
  logic [2:0]          rd_k_r, rd_end_r, rd_k_q_r;
  logic                rd_vld_r;
  logic [3:0]          car_r;
  logic [8:0]          acc_r;
  logic [6:0]          kc_r;
  logic [CH_BITS-1:0]  tick_ch_r;
  logic [7:0]          clr_addr_r;

  // shadow memory
  logic [7:0] mem [256];
  logic       mem_we;
  logic [7:0] mem_waddr, mem_wdata, mem_raddr, rdata_r;
  logic       mem_re;

  // per-channel state
  logic [6:0]            chan_note_r  [NUM_CHANNELS];
  logic [6:0]            chan_vel_r   [NUM_CHANNELS];
  logic                  chan_key_r   [NUM_CHANNELS];
  logic [3:0]            chan_mask_r  [NUM_CHANNELS];
  logic [COUNT_BITS-1:0] chan_cnt_r   [NUM_CHANNELS];
  logic [COUNT_BITS-1:0] chan_peak_r  [NUM_CHANNELS];
  logic [7:0]            chan_hold_r  [NUM_CHANNELS];

  // result register
  logic                  out_valid_r;
  logic [CH_BITS-1:0]    o_ch_r;
  logic [6:0]            o_note_r, o_vel_r;
  logic                  o_key_r;
  logic [3:0]            o_mask_r;
  logic [1:0]            o_edge_r;
  logic [15:0]           o_cnt_r, o_peak_r;
  logic [7:0]            o_rv_r;
  logic                  o_last_r;

  // input unpacking
  logic [1:0] in_cmd;
  logic [7:0] in_addr, in_data;
  assign in_cmd  = in_tuser;
  assign in_addr = in_tdata[7:0];
  assign in_data = in_tdata[15:8];

  logic in_fire, slot_free, out_load, tick_fire;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign tick_fire = (state_r == ST_TICK) && slot_free;
  assign out_load  = ((state_r == ST_EMIT) && slot_free) || tick_fire;

  // write decode at acceptance
  logic [CH_BITS-1:0] w_ch;
  logic               w_counted, w_key, w_vel, w_note, w_now;
  logic [3:0]         w_slots;
  kind_t              w_kind;
  always_comb begin
    w_key     = (in_addr == ADDR_KEY);
    w_ch      = w_key ? in_data[CH_BITS-1:0] : in_addr[CH_BITS-1:0];
    w_counted = w_key || (in_addr >= ADDR_CHAN_LO);
    w_vel     = ((in_addr >= ADDR_CHAN_LO) && (in_addr <= ADDR_ALG_HI)) ||
                ((in_addr >= ADDR_TL_LO) && (in_addr <= ADDR_TL_HI));
    w_note    = (in_addr >= ADDR_KC_LO) && (in_addr <= ADDR_KC_HI);
    w_slots   = in_data[6:3];
    w_now     = (w_slots != 4'd0);
    if (w_vel)       w_kind = K_VEL;
    else if (w_note) w_kind = K_NOTE;
    else             w_kind = K_PLAIN;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:   if (clr_addr_r == 8'hFF) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            CMD_WRITE: state_nxt = (w_vel || w_note) ? ST_RD : ST_EMIT;
            CMD_TICK,
            CMD_READ:  state_nxt = ST_RD;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD:    if (rd_k_r == rd_end_r) state_nxt = ST_DRAIN;
      ST_DRAIN: begin
        case (kind_r)
          K_NOTE, K_VEL: state_nxt = ST_CALC;
          K_TICK:        state_nxt = ST_TICK;
          default:       state_nxt = ST_EMIT;
        endcase
      end
      ST_CALC:  state_nxt = ST_EMIT;
      ST_EMIT:  if (slot_free) state_nxt = ST_IDLE;
      ST_TICK:  if (slot_free && (tick_ch_r == CH_BITS'(NUM_CHANNELS - 1))) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_cfg_r <= HOLD_RESET;
    end else if (cfg_we) begin
      hold_cfg_r <= cfg_wdata;
    end
  end

  // shadow memory ports
  always_comb begin
    mem_we    = (state_r == ST_CLR) || (in_fire && (in_cmd == CMD_WRITE));
    mem_waddr = (state_r == ST_CLR) ? clr_addr_r : in_addr;
    mem_wdata = (state_r == ST_CLR) ? 8'd0 : in_data;
    mem_re    = (state_r == ST_RD);
    case (kind_r)
      K_VEL: begin
        if (rd_k_r == 3'd0) mem_raddr = {5'b00100, ch_r};
        else                mem_raddr = {3'b011, 2'(rd_k_r - 3'd1), ch_r};
      end
      K_NOTE:  mem_raddr = {5'b00101, ch_r};
      default: mem_raddr = addr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  // sequencer and read-data processing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= 8'd0;
      rd_vld_r   <= 1'b0;
      rd_k_r     <= 3'd0;
      tick_ch_r  <= '0;
    end else begin
      if (state_r == ST_CLR) clr_addr_r <= clr_addr_r + 8'd1;
      rd_vld_r <= mem_re;
      rd_k_q_r <= rd_k_r;
      if (mem_re) rd_k_r <= rd_k_r + 3'd1;
      if (in_fire) begin
        rd_k_r    <= 3'd0;
        tick_ch_r <= '0;
      end
      if (tick_fire) tick_ch_r <= tick_ch_r + CH_BITS'(1);
    end
  end

  // item context capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      addr_r    <= in_addr;
      acc_r     <= 9'd0;
      reg_val_r <= in_data;
      edge_r    <= 2'd0;
      case (in_cmd)
        CMD_WRITE: begin
          kind_r   <= w_kind;
          ch_r     <= w_ch;
          rd_end_r <= w_vel ? 3'd4 : 3'd0;
          if (w_key && w_now && !chan_key_r[w_ch])      edge_r <= 2'd1;
          else if (w_key && !w_now && chan_key_r[w_ch]) edge_r <= 2'd2;
        end
        CMD_TICK: begin
          kind_r   <= K_TICK;
          ch_r     <= in_addr[CH_BITS-1:0];
          rd_end_r <= 3'd0;
        end
        default: begin
          kind_r   <= K_READ;
          ch_r     <= in_addr[CH_BITS-1:0];
          rd_end_r <= 3'd0;
        end
      endcase
    end else if (rd_vld_r) begin
      case (kind_r)
        K_VEL: begin
          if (rd_k_q_r == 3'd0) begin
            car_r <= carrier_bits(rdata_r[2:0]);
          end else if (car_r[2'(rd_k_q_r - 3'd1)]) begin
            acc_r <= acc_r + {2'b00, ~rdata_r[6:0]};
          end
        end
        K_NOTE:  kc_r      <= rdata_r[6:0];
        default: reg_val_r <= rdata_r;
      endcase
    end
  end

  // velocity divide and note derivation
  logic [2:0]  car_n;
  logic [16:0] prod3;
  logic [8:0]  vel_q;
  logic [7:0]  note_sum;
  logic [6:0]  note_val;
  always_comb begin
    car_n = {2'b00, car_r[0]} + {2'b00, car_r[1]} + {2'b00, car_r[2]} + {2'b00, car_r[3]};
    prod3 = 17'(acc_r) * 17'(RECIP3);
    case (car_n)
      3'd1:    vel_q = acc_r;
      3'd2:    vel_q = acc_r >> 1;
      3'd3:    vel_q = {1'b0, prod3[16:9]};
      3'd4:    vel_q = acc_r >> 2;
      default: vel_q = 9'd0;
    endcase
    note_sum = {1'b0, kc_r[6:4], 4'b0000} - {3'b000, kc_r[6:4], 2'b00}
             + {4'b0000, kc_note(kc_r[3:0])} + 8'd2;
    note_val = (note_sum > {1'b0, NOTE_MAX}) ? NOTE_MAX : note_sum[6:0];
  end

  // frame tick peak update for the channel in turn
  logic [COUNT_BITS-1:0] t_cnt, t_peak, t_peak_nxt;
  logic [7:0]            t_hold, t_hold_nxt;
  always_comb begin
    t_cnt      = chan_cnt_r[tick_ch_r];
    t_peak     = chan_peak_r[tick_ch_r];
    t_hold     = chan_hold_r[tick_ch_r];
    t_peak_nxt = t_peak;
    t_hold_nxt = t_hold;
    if (t_cnt > t_peak) begin
      t_peak_nxt = t_cnt;
      t_hold_nxt = hold_cfg_r;
    end else if (t_hold != 8'd0) begin
      t_hold_nxt = t_hold - 8'd1;
      if (t_hold == 8'd1) t_peak_nxt = '0;
    end
  end

  // per-channel state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_note_r[i] <= '0;
        chan_vel_r[i]  <= '0;
        chan_key_r[i]  <= 1'b0;
        chan_mask_r[i] <= '0;
        chan_cnt_r[i]  <= '0;
        chan_peak_r[i] <= '0;
        chan_hold_r[i] <= '0;
      end
    end else begin
      if (in_fire && (in_cmd == CMD_WRITE)) begin
        if (w_counted && (chan_cnt_r[w_ch] != CNT_MAX))
          chan_cnt_r[w_ch] <= chan_cnt_r[w_ch] + COUNT_BITS'(1);
        if (w_key) begin
          chan_key_r[w_ch]  <= w_now;
          chan_mask_r[w_ch] <= w_slots;
        end
      end
      if (state_r == ST_CALC) begin
        if (kind_r == K_NOTE) chan_note_r[ch_r] <= note_val;
        else                  chan_vel_r[ch_r]  <= vel_q[6:0];
      end
      if (tick_fire) begin
        chan_peak_r[tick_ch_r] <= t_peak_nxt;
        chan_hold_r[tick_ch_r] <= t_hold_nxt;
        chan_cnt_r[tick_ch_r]  <= '0;
      end
    end
  end

  // result register
  logic [CH_BITS-1:0] sel_ch;
  logic [31:0]        cnt_ext, peak_ext;
  always_comb begin
    sel_ch   = (state_r == ST_TICK) ? tick_ch_r : ch_r;
    cnt_ext  = 32'(chan_cnt_r[sel_ch]);
    peak_ext = (state_r == ST_TICK) ? 32'(t_peak_nxt) : 32'(chan_peak_r[sel_ch]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_ch_r   <= sel_ch;
      o_note_r <= chan_note_r[sel_ch];
      o_vel_r  <= chan_vel_r[sel_ch];
      o_key_r  <= chan_key_r[sel_ch];
      o_mask_r <= chan_mask_r[sel_ch];
      o_edge_r <= (state_r == ST_TICK) ? 2'd0 : edge_r;
      o_cnt_r  <= cnt_ext[15:0];
      o_peak_r <= peak_ext[15:0];
      o_rv_r   <= reg_val_r;
      o_last_r <= (state_r != ST_TICK) || (tick_ch_r == CH_BITS'(NUM_CHANNELS - 1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {o_rv_r, o_peak_r, o_cnt_r, o_edge_r, o_mask_r, o_key_r,
                       o_vel_r, o_note_r, o_ch_r};

  // checks
  `include "fm_register_write_monitor_core_assert.svh"

  `FMWM_ASSERT_SAME(a_no_overwrite, out_load, (!out_valid_r || out_tready), "result overwritten while stalled")
  `FMWM_ASSERT_SAME(a_rdata_from_rd, rd_vld_r, ($past(state_r) == ST_RD), "read data without a read")
  `FMWM_ASSERT_NEXT(a_tick_ends, (tick_fire && o_last_r == 1'b0 && tick_ch_r == CH_BITS'(NUM_CHANNELS - 1)), (state_r == ST_IDLE && out_tlast), "tick did not end on last channel")
  `FMWM_ASSERT_SAME(a_no_accept_busy, (in_fire), (state_r == ST_IDLE && !rd_vld_r), "item accepted while busy")

endmodule
